@@ rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and default sizes shared by the semaphore table files.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int SEM_ID_W = 4;
	localparam int INIT_W   = 16;
	localparam int PID_W    = 8;
	localparam int COUNT_W  = 16;
	localparam int REFS_W   = 8;

	localparam int DEF_NUM_SEMS    = 16;
	localparam int DEF_MAX_WAITERS = 16;
	localparam int DEF_PID_BITS    = 8;
	localparam int DEF_COUNT_BITS  = 16;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_POST  = 2'd2,
		CMD_WAIT  = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_QUEUE_FULL = 3'd4
	} status_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [SEM_ID_W-1:0]   sem_id;
		logic [INIT_W-1:0]     init_value;
		logic [PID_W-1:0]      pid;
	} cmd_t;

	typedef struct packed {
		status_t               status;
		logic                  wake_valid;
		logic [PID_W-1:0]      wake_pid;
		logic                  caller_blocks;
		logic [COUNT_W-1:0]    count_out;
	} result_t;

endpackage

@@ rtl/cst_wait_ram.sv @@
// ----------------------------------------------------------------------------
// cst_wait_ram
// Wait queue storage: one waiter id per row, a block of rows per slot, registered read.
// ----------------------------------------------------------------------------
module cst_wait_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/counting_semaphore_table_core.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Table of counting semaphores with a FIFO of waiting process ids per slot.
// ----------------------------------------------------------------------------
// On accept the command is registered and the head of the slot's wait queue
// is read from memory; the update stage then writes the slot and registers
// the result. busy is high during the update stage, so a new command is not
// accepted while one is being updated. The result is
// shown for one cycle with done high; the receiver cannot stall it, so it
// must take it then.
module counting_semaphore_table_core #(
	parameter int NUM_SEMS    = cst_pkg::DEF_NUM_SEMS,
	parameter int MAX_WAITERS = cst_pkg::DEF_MAX_WAITERS,
	parameter int PID_BITS    = cst_pkg::DEF_PID_BITS,
	parameter int COUNT_BITS  = cst_pkg::DEF_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cst_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output cst_pkg::result_t result
);

	import cst_pkg::*;

	localparam int SIW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int LW  = $clog2(MAX_WAITERS + 1);
	localparam int SW  = HW + 1;
	localparam int DEPTH = NUM_SEMS * MAX_WAITERS;
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic                  slot_used_q [NUM_SEMS];
	logic [COUNT_BITS-1:0] permit_q    [NUM_SEMS];
	logic [REFS_W-1:0]     refs_q      [NUM_SEMS];
	logic [HW-1:0]         head_q      [NUM_SEMS];
	logic [LW-1:0]         len_q       [NUM_SEMS];

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [SIW-1:0]        slot_s1;
	logic                  range_s1;
	logic                  done_q;
	result_t               result_q;

	logic                  accept;
	logic                  in_range;
	logic [SIW-1:0]        slot_in;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [PID_BITS-1:0]   rd_pid;
	logic [PID_BITS-1:0]   pid_st;

	logic                  used_cur;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [REFS_W-1:0]     refs_cur;
	logic [HW-1:0]         head_cur;
	logic [LW-1:0]         len_cur;
	logic [COUNT_BITS-1:0] init_sat;
	logic [SW-1:0]         tail_sum;
	logic [HW-1:0]         tail;

	logic                  used_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [REFS_W-1:0]     refs_d;
	logic [HW-1:0]         head_d;
	logic [LW-1:0]         len_d;
	logic                  enq;
	result_t               res_d;

	assign accept   = start && !busy;
	assign in_range = 32'(cmd.sem_id) < NUM_SEMS;
	assign slot_in  = in_range ? SIW'(cmd.sem_id) : '0;
	assign rd_addr  = AW'(AW'(slot_in) * AW'(MAX_WAITERS)) + AW'(head_q[slot_in]);
	assign pid_st   = PID_BITS'(cmd_s1.pid);

	cst_wait_ram #(
		.DEPTH (DEPTH),
		.WIDTH (PID_BITS),
		.AW    (AW)
	) u_wait_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_pid),
		.wr_en   (valid_s1 && enq),
		.wr_addr (wr_addr),
		.wr_data (pid_st)
	);

	assign used_cur = slot_used_q[slot_s1];
	assign cnt_cur  = permit_q[slot_s1];
	assign refs_cur = refs_q[slot_s1];
	assign head_cur = head_q[slot_s1];
	assign len_cur  = len_q[slot_s1];
	assign init_sat = (32'(cmd_s1.init_value) > 32'(CNT_MAX)) ? CNT_MAX
	                  : COUNT_BITS'(cmd_s1.init_value);
	assign tail_sum = SW'(head_cur) + SW'(len_cur);
	assign tail     = (tail_sum >= SW'(MAX_WAITERS)) ? HW'(tail_sum - SW'(MAX_WAITERS))
	                  : HW'(tail_sum);
	assign wr_addr  = AW'(AW'(slot_s1) * AW'(MAX_WAITERS)) + AW'(tail);

	always_comb begin
		used_d = used_cur;
		cnt_d  = cnt_cur;
		refs_d = refs_cur;
		head_d = head_cur;
		len_d  = len_cur;
		enq    = 1'b0;
		res_d  = '0;
		res_d.status = ST_OK;
		if (!range_s1) begin
			res_d.status = ST_NOT_FOUND;
		end else if (cmd_s1.kind == CMD_OPEN) begin
			if (used_cur) begin
				if (refs_cur != REFS_MAX) begin
					refs_d = refs_cur + 1'b1;
				end
			end else begin
				used_d = 1'b1;
				cnt_d  = init_sat;
				refs_d = REFS_W'(1);
				head_d = '0;
				len_d  = '0;
			end
			res_d.count_out = COUNT_W'(cnt_d);
		end else if (!used_cur) begin
			res_d.status = ST_NOT_FOUND;
		end else begin
			unique case (cmd_s1.kind)
				CMD_CLOSE: begin
					if (refs_cur > REFS_W'(1)) begin
						refs_d = refs_cur - 1'b1;
						res_d.status = ST_DROPPED;
						res_d.count_out = COUNT_W'(cnt_cur);
					end else begin
						used_d = 1'b0;
						res_d.status = ST_REMOVED;
					end
				end
				CMD_POST: begin
					if (len_cur != '0) begin
						res_d.wake_valid = 1'b1;
						res_d.wake_pid = PID_W'(rd_pid);
						head_d = (head_cur == HW'(MAX_WAITERS - 1)) ? '0
						         : head_cur + 1'b1;
						len_d = len_cur - 1'b1;
					end else if (cnt_cur != CNT_MAX) begin
						cnt_d = cnt_cur + 1'b1;
					end
					res_d.count_out = COUNT_W'(cnt_d);
				end
				CMD_WAIT: begin
					if (cnt_cur != '0) begin
						cnt_d = cnt_cur - 1'b1;
					end else if (32'(len_cur) >= MAX_WAITERS) begin
						res_d.status = ST_QUEUE_FULL;
					end else begin
						enq = 1'b1;
						len_d = len_cur + 1'b1;
						res_d.caller_blocks = 1'b1;
					end
					res_d.count_out = COUNT_W'(cnt_d);
				end
				default: begin
					res_d.status = ST_NOT_FOUND;
				end
			endcase
		end
	end

	// mark the update cycle and register done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			slot_s1  <= slot_in;
			range_s1 <= in_range;
		end
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				slot_used_q[i] <= 1'b0;
			end
		end else if (valid_s1 && range_s1) begin
			slot_used_q[slot_s1] <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && range_s1) begin
			permit_q[slot_s1] <= cnt_d;
			refs_q[slot_s1]   <= refs_d;
			head_q[slot_s1]   <= head_d;
			len_q[slot_s1]    <= len_d;
		end
	end

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/cst_checker.sv @@
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on command timing and result consistency.
// ----------------------------------------------------------------------------
module cst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input cst_pkg::result_t result
);

	import cst_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("busy not raised after accept");

	a_done_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 (done && !busy))
		else $error("result word missing two cycles after accept");

	a_done_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command in flight");

	a_wake_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.wake_valid) |-> (result.wake_pid == '0))
		else $error("wake_pid set without a wake");

	a_block_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.caller_blocks) |->
			(result.status == ST_OK && result.count_out == '0 && !result.wake_valid))
		else $error("blocking wait with inconsistent result");

endmodule

bind counting_semaphore_table_core cst_checker u_cst_checker (.*);

@@ tb/sv/counting_semaphore_table_checker.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_table_checker
// Watches the command and result channels of the semaphore table, keeps its
// own copy of every slot, predicts the reply to each accepted command and
// compares the replies in order, field by field.
// ----------------------------------------------------------------------------
module counting_semaphore_table_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cst_pkg::cmd_t    cmd,
	input  logic             busy,
	input  logic             done,
	input  cst_pkg::result_t result,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	import cst_pkg::*;

	localparam int SLOTS = DEF_NUM_SEMS;
	localparam int DEPTH = DEF_MAX_WAITERS;
	localparam int HEAD_W = $clog2(DEPTH);
	localparam logic [COUNT_W-1:0] PERMIT_MAX = '1;

	logic                live    [SLOTS];
	logic [COUNT_W-1:0]  permits [SLOTS];
	logic [REFS_W-1:0]   refs    [SLOTS];
	logic [PID_W-1:0]    waiters [SLOTS][DEPTH];
	logic [HEAD_W-1:0]   head    [SLOTS];
	logic [HEAD_W:0]     qlen    [SLOTS];

	result_t owed_replies[$];
	result_t want;

	function automatic result_t serve_command(cmd_t c);
		result_t r;
		int s;
		logic [HEAD_W-1:0] tail;
		r = '0;
		s = int'(c.sem_id);
		if (c.kind == CMD_OPEN) begin
			if (live[s]) begin
				if (refs[s] != REFS_MAX)
					refs[s] = refs[s] + 1'b1;
			end else begin
				live[s] = 1'b1;
				permits[s] = c.init_value;
				refs[s] = REFS_W'(1);
				head[s] = '0;
				qlen[s] = '0;
			end
			r.count_out = permits[s];
		end else if (!live[s]) begin
			r.status = ST_NOT_FOUND;
		end else begin
			case (c.kind)
				CMD_CLOSE: begin
					if (refs[s] > 1) begin
						refs[s] = refs[s] - 1'b1;
						r.status = ST_DROPPED;
						r.count_out = permits[s];
					end else begin
						live[s] = 1'b0;
						r.status = ST_REMOVED;
					end
				end
				CMD_POST: begin
					if (qlen[s] != 0) begin
						r.wake_valid = 1'b1;
						r.wake_pid = waiters[s][head[s]];
						head[s] = head[s] + 1'b1;
						qlen[s] = qlen[s] - 1'b1;
					end else if (permits[s] != PERMIT_MAX) begin
						permits[s] = permits[s] + 1'b1;
					end
					r.count_out = permits[s];
				end
				default: begin
					if (permits[s] != 0) begin
						permits[s] = permits[s] - 1'b1;
					end else if (qlen[s] >= DEPTH) begin
						r.status = ST_QUEUE_FULL;
					end else begin
						tail = head[s] + qlen[s][HEAD_W-1:0];
						waiters[s][tail] = c.pid;
						qlen[s] = qlen[s] + 1'b1;
						r.caller_blocks = 1'b1;
					end
					r.count_out = permits[s];
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				live[i] = 1'b0;
			owed_replies.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_replies.size() == 0) begin
					$error("result word with no command waiting: status %0d count_out %0d",
						result.status, result.count_out);
					fail_count++;
				end else begin
					want = owed_replies.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
					if (result.wake_valid !== want.wake_valid) begin
						$error("wake_valid: expected %0d, got %0d",
							want.wake_valid, result.wake_valid);
						fail_count++;
					end
					if (result.wake_pid !== want.wake_pid) begin
						$error("wake_pid: expected %0d, got %0d", want.wake_pid, result.wake_pid);
						fail_count++;
					end
					if (result.caller_blocks !== want.caller_blocks) begin
						$error("caller_blocks: expected %0d, got %0d",
							want.caller_blocks, result.caller_blocks);
						fail_count++;
					end
					if (result.count_out !== want.count_out) begin
						$error("count_out: expected %0d, got %0d",
							want.count_out, result.count_out);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				owed_replies.push_back(serve_command(cmd));
			pending <= owed_replies.size();
		end
	end

endmodule

@@ tb/sv/counting_semaphore_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_table_core_tb
// Drives open, close, post and wait commands into the semaphore table: a
// directed opening for the corner cases, then random slot sessions, queue
// fills, stray commands and a reference storm, under several idle patterns.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core_tb;

	import cst_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	cmd_t        cmd = '0;
	logic        busy;
	logic        done;
	result_t     result;
	int unsigned fail_count;
	int unsigned pending;
	int          idle_pct = 0;
	int unsigned sent = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	counting_semaphore_table_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	counting_semaphore_table_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [INIT_W-1:0] pick_init();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return '0;
		if (roll < 75)
			return INIT_W'($urandom_range(1, 6));
		if (roll < 85)
			return {{(INIT_W-1){1'b1}}, 1'($urandom_range(1))};
		return INIT_W'($urandom);
	endfunction

	task automatic issue(input cmd_kind_t k, input int s, input logic [INIT_W-1:0] v,
			input logic [PID_W-1:0] p);
		cmd_t c;
		c.kind = k;
		c.sem_id = s[SEM_ID_W-1:0];
		c.init_value = v;
		c.pid = p;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= cmd_t'(30'($urandom));
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_sequence();
		int roll;
		int s;
		int n;
		cmd_kind_t k;
		roll = $urandom_range(99);
		s = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
		if (roll < 10) begin
			issue(cmd_kind_t'($urandom_range(3)), $urandom_range(15), INIT_W'($urandom),
				PID_W'($urandom));
		end else if (roll < 20) begin
			n = $urandom_range(1, 4);
			repeat (n)
				issue(cmd_kind_t'($urandom_range(1, 3)), $urandom_range(15),
					INIT_W'($urandom), PID_W'($urandom));
		end else if (roll < 35) begin
			issue(CMD_OPEN, s, '0, PID_W'($urandom));
			n = $urandom_range(12, 18);
			repeat (n)
				issue(CMD_WAIT, s, INIT_W'($urandom), PID_W'($urandom));
			n = $urandom_range(1, 20);
			repeat (n)
				issue(CMD_POST, s, INIT_W'($urandom), PID_W'($urandom));
			if ($urandom_range(1))
				issue(CMD_CLOSE, s, INIT_W'($urandom), PID_W'($urandom));
		end else begin
			issue(CMD_OPEN, s, pick_init(), PID_W'($urandom));
			n = $urandom_range(3, 16);
			repeat (n) begin
				roll = $urandom_range(99);
				if (roll < 45)
					k = CMD_WAIT;
				else if (roll < 80)
					k = CMD_POST;
				else if (roll < 90)
					k = CMD_OPEN;
				else
					k = CMD_CLOSE;
				issue(k, s, pick_init(), PID_W'($urandom));
			end
		end
	endtask

	initial begin
		int target;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_CLOSE, 3, '0, '0);
		issue(CMD_OPEN, 15, '1, '1);
		issue(CMD_POST, 15, '0, '0);
		issue(CMD_WAIT, 15, '0, 8'h5A);
		issue(CMD_OPEN, 15, '0, '0);
		issue(CMD_CLOSE, 15, '1, '1);
		issue(CMD_CLOSE, 15, '0, '0);
		issue(CMD_OPEN, 0, '0, '0);
		for (int i = 0; i < DEF_MAX_WAITERS; i++)
			issue(CMD_WAIT, 0, '0, PID_W'(8'hA0 + i));
		issue(CMD_WAIT, 0, '0, '1);
		issue(CMD_POST, 0, '0, '0);
		issue(CMD_CLOSE, 0, '0, '0);
		issue(CMD_POST, 0, '0, '0);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 86;
				2: idle_pct = 0;
				default: idle_pct = 19;
			endcase
			target = sent + 70;
			if (ph == 2) begin
				repeat (258)
					issue(CMD_OPEN, 9, pick_init(), PID_W'($urandom));
				repeat (4)
					issue(CMD_CLOSE, 9, pick_init(), PID_W'($urandom));
			end
			while (sent < target)
				random_sequence();
			settle();
		end

		repeat (8)
			@(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
